// File: design/shortest_column_placer_unit_macros.svh
// Assertion macros for the shortest column placer
`ifndef SHORTEST_COLUMN_PLACER_UNIT_MACROS_SVH
`define SHORTEST_COLUMN_PLACER_UNIT_MACROS_SVH

// check that a condition implies a consequence at the same edge
`define SCP_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scp assertion failed: implication");

// check that a condition holds at every edge out of reset
`define SCP_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("scp assertion failed: invariant");

`endif

// File: design/scp_pkg.sv
// Types and constants shared by the shortest column placer
`timescale 1ns / 1ps

package scp_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_CNT_W   = 5;
    localparam int HEIGHT_W    = 24;
    localparam int ITEM_W      = 16;
    localparam int OUT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = HEIGHT_W + 2;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTAINER_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_SIZE        = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [HEIGHT_W-1:0]  height;
        logic [COL_IDX_W-1:0] idx;
    } t_cand;

    typedef struct packed {
        logic                 clear;
        logic                 wr_en;
        logic [COL_IDX_W-1:0] wr_idx;
        logic [HEIGHT_W-1:0]  wr_data;
    } t_cell_ctrl;

endpackage

// File: design/scp_if.sv
// Handshake channels of the shortest column placer: item, result, configuration
`timescale 1ns / 1ps

interface scp_item_if import scp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITEM_W-1:0] item_height;
    logic              first_of_list;

    modport source (output valid, item_height, first_of_list, input ready);
    modport sink   (input valid, item_height, first_of_list, output ready);
endinterface

interface scp_result_if import scp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] column_index;
    logic [HEIGHT_W-1:0]  top_position;
    logic [ITEM_W-1:0]    placed_height;
    logic                 overflowed;

    modport source (output valid, column_index, top_position, placed_height, overflowed,
                    input ready);
    modport sink   (input valid, column_index, top_position, placed_height, overflowed,
                    output ready);
endinterface

interface scp_cfg_if import scp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: design/scp_cell.sv
// One column cell: holds a column height and forwards the running minimum
`timescale 1ns / 1ps

module scp_cell import scp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [COL_IDX_W-1:0] i_index,
    input  logic                 i_active,
    input  t_cell_ctrl           i_ctrl,
    input  t_cand                i_cand,
    output t_cand                o_cand
);

    logic [HEIGHT_W-1:0] r_height;
    t_cand               r_cand;
    t_cand               n_cand;

    always_comb begin
        n_cand = i_cand;
        if (i_cand.valid && i_active && (!i_cand.found || (r_height < i_cand.height))) begin
            n_cand.found  = 1'b1;
            n_cand.height = r_height;
            n_cand.idx    = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= '0;
        end else if (i_ctrl.clear) begin
            r_height <= '0;
        end else if (i_ctrl.wr_en && (i_ctrl.wr_idx == i_index)) begin
            r_height <= i_ctrl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid <= n_cand.valid;
        end
        r_cand.found  <= n_cand.found;
        r_cand.height <= n_cand.height;
        r_cand.idx    <= n_cand.idx;
    end

    assign o_cand = r_cand;

endmodule

// File: design/shortest_column_placer_unit.sv
// Top level of the shortest column placer: control, configuration and cell row
//
//  channel   | direction | word
//  ----------+-----------+------------------------------------------------
//  i_item    | in        | item_height, first_of_list
//  o_result  | out       | column_index, top_position, placed_height, overflowed
//  i_cfg     | in        | reg_index, wr_data
//
// An item is handled in order: a register loads the minimum token, the token
// walks the cell row one cell per cycle, a register latches the minimum, then the
// chosen column is added to and written back.
// An item with zero columns or zero width is accepted and gives no word.
// Synchronous active-low reset clears the columns and loads the register defaults.
// A stalled result holds the write-back until the output register frees.
`timescale 1ns / 1ps

`include "shortest_column_placer_unit_macros.svh"

module shortest_column_placer_unit import scp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scp_item_if.sink      i_item,
    scp_cfg_if.sink       i_cfg,
    scp_result_if.source  o_result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [COL_CNT_W-1:0]   r_column_count;
    logic [ITEM_W-1:0]      r_container_width;
    logic [ITEM_W-1:0]      r_gap_size;
    logic [ITEM_W-1:0]      r_item_height;
    logic                   r_inject;
    logic [COL_IDX_W-1:0]   r_best;
    logic [HEIGHT_W-1:0]    r_top;
    logic                   r_out_valid;
    logic [OUT_IDX_W-1:0]   r_out_index;
    logic [HEIGHT_W-1:0]    r_out_top;
    logic [ITEM_W-1:0]      r_out_height;
    logic                   r_out_over;

    logic [COL_CNT_W-1:0]   w_active_eff;
    logic                   w_suppress;
    logic                   w_item_acc;
    logic                   w_out_free;
    logic                   w_write;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_over;
    logic [HEIGHT_W-1:0]    w_new_height;
    logic [MAX_COLUMNS-1:0] w_active;
    logic [MAX_COLUMNS-1:0] w_tok_valid;
    t_cell_ctrl             w_ctrl;
    t_cand                  w_cand [MAX_COLUMNS+1];

    assign w_active_eff = (r_column_count > COL_CNT_W'(MAX_COLUMNS)) ?
                          COL_CNT_W'(MAX_COLUMNS) : r_column_count;
    assign w_suppress   = (w_active_eff == '0) || (r_container_width == '0);
    assign i_item.ready = (r_state == ST_IDLE);
    assign w_item_acc   = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_write      = (r_state == ST_UPDATE) && w_out_free;

    assign w_sum        = SUM_W'(r_top) + SUM_W'(r_item_height) + SUM_W'(r_gap_size);
    assign w_over       = (w_sum > SUM_W'(HEIGHT_MAX));
    assign w_new_height = w_over ? HEIGHT_MAX : w_sum[HEIGHT_W-1:0];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count    <= COL_CNT_W'(1);
            r_container_width <= ITEM_W'(1);
            r_gap_size        <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                REG_COLUMN_COUNT:    r_column_count    <= i_cfg.wr_data[COL_CNT_W-1:0];
                REG_CONTAINER_WIDTH: r_container_width <= i_cfg.wr_data[ITEM_W-1:0];
                REG_GAP_SIZE:        r_gap_size        <= i_cfg.wr_data[ITEM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_item_acc && !w_suppress) n_state = ST_SWEEP;
            ST_SWEEP:  if (w_cand[MAX_COLUMNS].valid) n_state = ST_UPDATE;
            ST_UPDATE: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_inject <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_item_acc && !w_suppress;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_item_acc) begin
            r_item_height <= i_item.item_height;
        end
        if ((r_state == ST_SWEEP) && w_cand[MAX_COLUMNS].valid) begin
            r_best <= w_cand[MAX_COLUMNS].idx;
            r_top  <= w_cand[MAX_COLUMNS].height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_write) begin
            r_out_index  <= OUT_IDX_W'(r_best);
            r_out_top    <= r_top;
            r_out_height <= r_item_height;
            r_out_over   <= w_over;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.column_index  = r_out_index;
    assign o_result.top_position  = r_out_top;
    assign o_result.placed_height = r_out_height;
    assign o_result.overflowed    = r_out_over;

    assign w_ctrl.clear   = w_item_acc && i_item.first_of_list;
    assign w_ctrl.wr_en   = w_write;
    assign w_ctrl.wr_idx  = r_best;
    assign w_ctrl.wr_data = w_new_height;

    assign w_cand[0] = '{valid: r_inject, found: 1'b0, height: '0, idx: '0};

    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        assign w_active[g]    = ({1'b0, w_active_eff} > (COL_CNT_W+1)'(g));
        assign w_tok_valid[g] = w_cand[g+1].valid;

        scp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (COL_IDX_W'(g)),
            .i_active (w_active[g]),
            .i_ctrl   (w_ctrl),
            .i_cand   (w_cand[g]),
            .o_cand   (w_cand[g+1])
        );
    end

    `SCP_ASSERT_ALWAYS(a_single_token, $onehot0({r_inject, w_tok_valid}))
    `SCP_ASSERT_IMPLIES(a_token_in_sweep, w_cand[MAX_COLUMNS].valid, r_state == ST_SWEEP)
    `SCP_ASSERT_IMPLIES(a_best_active, r_state == ST_UPDATE, w_active[r_best])

endmodule

// File: bench/shortest_column_placer_unit_test.sv
// Self-checking testbench for the shortest column placer: directed and random placement
`timescale 1ns / 1ps

module shortest_column_placer_unit_test;
    import scp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = MAX_COLUMNS + 8;
    localparam int PLACEMENT_GOAL = 1250;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] column;
        logic [HEIGHT_W-1:0]  top;
        logic [ITEM_W-1:0]    height;
        logic                 over;
    } t_placement;

    logic i_clk;
    logic i_rst_n;

    scp_item_if   item_ch ();
    scp_cfg_if    cfg_ch ();
    scp_result_if result_ch ();

    shortest_column_placer_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    logic [HEIGHT_W-1:0]  col_height [MAX_COLUMNS];
    logic [COL_CNT_W-1:0] cur_col_count;
    logic [ITEM_W-1:0]    cur_width;
    logic [ITEM_W-1:0]    cur_gap;

    t_placement placements_due [$];
    t_placement want;
    int         error_count;
    int         placed_count;
    bit         tx_idle_on;
    bit         rx_stall_on;
    int         ready_hold;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic bit predict_placement(input logic [ITEM_W-1:0] h, input logic first);
        int         active;
        int         best;
        int         c;
        logic [SUM_W-1:0] sum;
        t_placement p;
        active = (cur_col_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(cur_col_count);
        if (first) begin
            for (c = 0; c < MAX_COLUMNS; c++) col_height[c] = '0;
        end
        if (active == 0 || cur_width == 0) begin
            return 1'b0;
        end
        best = 0;
        for (c = 1; c < active; c++) begin
            if (col_height[c] < col_height[best]) best = c;
        end
        sum = SUM_W'(col_height[best]) + SUM_W'(h) + SUM_W'(cur_gap);
        p.column = best[OUT_IDX_W-1:0];
        p.top    = col_height[best];
        p.height = h;
        p.over   = (sum > SUM_W'(HEIGHT_MAX));
        col_height[best] = p.over ? HEIGHT_MAX : sum[HEIGHT_W-1:0];
        placements_due.insert(placements_due.size(), p);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("mismatch %s: expected 0x%0h got 0x%0h at %0t ns",
                     what, exp_val, got_val, $realtime);
        end
    endtask

    task automatic send_item(input logic [ITEM_W-1:0] h, input logic first);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid         = 1'b1;
        item_ch.item_height   = h;
        item_ch.first_of_list = first;
        do @(posedge i_clk); while (!item_ch.ready);
        if (predict_placement(h, first)) placed_count++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_COLUMN_COUNT:    cur_col_count = data[COL_CNT_W-1:0];
            REG_CONTAINER_WIDTH: cur_width     = data;
            REG_GAP_SIZE:        cur_gap       = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_layout(input int count, input logic [15:0] width, input logic [15:0] gap);
        write_reg(REG_COLUMN_COUNT, 16'(count));
        write_reg(REG_CONTAINER_WIDTH, width);
        write_reg(REG_GAP_SIZE, gap);
    endtask

    task automatic test_reset_defaults();
        send_item(16'h0000, 1'b1);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h1234, 1'b0);
    endtask

    task automatic test_tie_break();
        wait_idle();
        set_layout(4, 16'd800, 16'd5);
        send_item(16'd10, 1'b1);
        send_item(16'd10, 1'b0);
        send_item(16'd10, 1'b0);
        send_item(16'd10, 1'b0);
        send_item(16'd3, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd40, 1'b0);
    endtask

    task automatic test_column_count();
        int k;
        wait_idle();
        set_layout(16, 16'hFFFF, 16'd0);
        send_item(16'd7, 1'b1);
        for (k = 1; k < MAX_COLUMNS; k++) send_item(16'd7, 1'b0);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'hFFFF);
        send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b0);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'd17);
        send_item(16'd3, 1'b0);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'd3);
        send_item(16'd100, 1'b0);
        send_item(16'd100, 1'b0);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'd16);
        send_item(16'd5, 1'b0);
        send_item(16'd5, 1'b0);
    endtask

    task automatic test_suppression();
        wait_idle();
        set_layout(2, 16'd1, 16'd9);
        send_item(16'd50, 1'b1);
        send_item(16'd60, 1'b0);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'd0);
        send_item(16'hABCD, 1'b0);
        send_item(16'h5432, 1'b1);
        wait_idle();
        write_reg(REG_COLUMN_COUNT, 16'd2);
        write_reg(REG_CONTAINER_WIDTH, 16'd0);
        send_item(16'd77, 1'b0);
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_CONTAINER_WIDTH, 16'd100);
        send_item(16'd8, 1'b0);
        send_item(16'd8, 1'b0);
    endtask

    task automatic test_saturation();
        int k;
        wait_idle();
        set_layout(1, 16'hFFFF, 16'hFFFF);
        send_item(16'hFFFF, 1'b1);
        for (k = 0; k < 140; k++) send_item(16'hFFFF, 1'b0);
    endtask

    function automatic logic [ITEM_W-1:0] random_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        if (r < 40) return ITEM_W'($urandom_range(0, 255));
        return ITEM_W'($urandom);
    endfunction

    task automatic random_config(output bit deep);
        int               r;
        logic [CFG_DATA_W-1:0] data;
        deep = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 99);
        data = CFG_DATA_W'($urandom);
        if (deep) begin
            data[COL_CNT_W-1:0] = COL_CNT_W'($urandom_range(1, 2));
        end else if (r < 5) begin
            data[COL_CNT_W-1:0] = '0;
        end else if (r < 15) begin
            data[COL_CNT_W-1:0] = COL_CNT_W'($urandom_range(17, 31));
        end else if (r < 25) begin
            data[COL_CNT_W-1:0] = COL_CNT_W'(MAX_COLUMNS);
        end else begin
            data[COL_CNT_W-1:0] = COL_CNT_W'($urandom_range(1, MAX_COLUMNS));
        end
        write_reg(REG_COLUMN_COUNT, data);
        r = $urandom_range(0, 99);
        if (deep) data = CFG_DATA_W'($urandom_range(1, 65535));
        else if (r < 4) data = '0;
        else if (r < 14) data = '1;
        else data = CFG_DATA_W'($urandom_range(1, 65535));
        write_reg(REG_CONTAINER_WIDTH, data);
        r = $urandom_range(0, 99);
        if (deep) data = CFG_DATA_W'($urandom_range(49152, 65535));
        else if (r < 30) data = '0;
        else if (r < 40) data = '1;
        else if (r < 75) data = CFG_DATA_W'($urandom_range(1, 300));
        else data = CFG_DATA_W'($urandom);
        write_reg(REG_GAP_SIZE, data);
    endtask

    task automatic test_random_layouts();
        bit deep;
        int lists;
        int len;
        int l;
        int k;
        logic first;
        while (placed_count < PLACEMENT_GOAL) begin
            wait_idle();
            random_config(deep);
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            lists = deep ? 1 : $urandom_range(1, 5);
            for (l = 0; l < lists; l++) begin
                if ($urandom_range(0, 4) == 0) drain_results();
                len = deep ? 180 * int'(cur_col_count) + $urandom_range(0, 40)
                           : $urandom_range(1, 30);
                for (k = 0; k < len; k++) begin
                    first = (k == 0);
                    if ($urandom_range(0, 9) == 0) first = 1'($urandom_range(0, 1));
                    send_item(deep ? ITEM_W'($urandom_range(32768, 65535)) : random_height(),
                              first);
                end
            end
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        ready_hold = 0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (!rx_stall_on || !result_ch.ready) begin
                result_ch.ready = 1'b1;
                ready_hold = $urandom_range(0, 6);
            end else begin
                result_ch.ready = 1'b0;
                ready_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (placements_due.size() == 0) begin
                report_mismatch("unexpected word, column", 32'hFFFF_FFFF,
                                32'(result_ch.column_index));
            end else begin
                want = placements_due.pop_front();
                if (result_ch.column_index !== want.column)
                    report_mismatch("column_index", 32'(want.column), 32'(result_ch.column_index));
                if (result_ch.top_position !== want.top)
                    report_mismatch("top_position", 32'(want.top), 32'(result_ch.top_position));
                if (result_ch.placed_height !== want.height)
                    report_mismatch("placed_height", 32'(want.height),
                                    32'(result_ch.placed_height));
                if (result_ch.overflowed !== want.over)
                    report_mismatch("overflowed", 32'(want.over), 32'(result_ch.overflowed));
            end
        end
    end

    initial begin
        int c;
        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.item_height   = '0;
        item_ch.first_of_list = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = '0;
        cfg_ch.wr_data        = '0;
        result_ch.ready       = 1'b0;
        error_count           = 0;
        placed_count          = 0;
        tx_idle_on            = 1'b1;
        rx_stall_on           = 1'b1;
        cur_col_count         = COL_CNT_W'(1);
        cur_width             = ITEM_W'(1);
        cur_gap               = '0;
        for (c = 0; c < MAX_COLUMNS; c++) col_height[c] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_tie_break();
        test_column_count();
        test_suppression();
        test_saturation();
        test_random_layouts();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
